FILE: design/kear_pkg.sv
// Shared types and constants for the key edge and auto-repeat tracker.
`timescale 1ns / 1ps

package kear_pkg;

   localparam int NUM_KEYS_DEF = 128;
   localparam int KEY_IDX_W    = 8;
   localparam int HOLD_W       = 16;
   localparam logic [HOLD_W-1:0] HOLD_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      FN_TICK    = 2'd0,
      FN_PRESSED = 2'd1,
      FN_TRIGGER = 2'd2,
      FN_RELEASE = 2'd3
   } func_type;

endpackage

FILE: design/kear_if.sv
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps

interface kear_req_if
   import kear_pkg::*;
();
   logic                 valid;
   logic                 ready;
   func_type             func;
   logic [KEY_IDX_W-1:0] key_index;
   logic                 raw_pressed;
   logic [HOLD_W-1:0]    hold_delay;
   logic [HOLD_W-1:0]    repeat_period;

   modport source (output valid, func, key_index, raw_pressed, hold_delay, repeat_period,
                   input ready);
   modport sink   (input valid, func, key_index, raw_pressed, hold_delay, repeat_period,
                   output ready);
endinterface

interface kear_rsp_if;
   logic valid;
   logic ready;
   logic answer;

   modport source (output valid, answer, input ready);
   modport sink   (input valid, answer, output ready);
endinterface

FILE: design/key_edge_and_autorepeat.sv
// A query reads its key entry, checks it and answers from the output register; a trigger
// query that needs the repeat check also waits for the 16-step remainder unit. A frame tick
// walks the key RAM, reading and then rewriting each key in turn. One transaction is in work
// at a time; a response waits in its output register until taken, and a finished transaction
// holds in its done state, taking no new request, until that register is free.
// Synchronous reset clears the written marks, so every key reads as released with a zero count.
`timescale 1ns / 1ps

module key_edge_and_autorepeat
   import kear_pkg::*;
#(
   parameter int NUM_KEYS = NUM_KEYS_DEF
) (
   input logic  clock,
   input logic  reset,
   kear_req_if.sink   req_bus,
   kear_rsp_if.source rsp_bus
);

   localparam int KEY_W   = $clog2(NUM_KEYS);
   localparam int ENTRY_W = HOLD_W + 2;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_QCHK = 6'b000010,
      S_QDIV = 6'b000100,
      S_TRD  = 6'b001000,
      S_TWR  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   func_type            func_ff, func_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic                key_ok_ff, key_ok_in;
   logic                raw_ff, raw_in;
   logic [KEY_W-1:0]    cnt_ff, cnt_in;
   logic [HOLD_W-1:0]   hold_ff, hold_in;
   logic [HOLD_W-1:0]   period_ff, period_in;
   logic                ans_ff, ans_in;
   logic [NUM_KEYS-1:0] hvalid_ff, hvalid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ans_ff, rsp_ans_in;

   logic                accept;
   logic                key_ok;
   logic [KEY_W-1:0]    req_key;
   logic                rsp_free;
   logic [ENTRY_W-1:0]  entry;
   logic                ent_now;
   logic                ent_before;
   logic [HOLD_W-1:0]   ent_held;
   logic [HOLD_W-1:0]   tick_held;
   logic                cur;
   logic                ram_wr_en;
   logic [KEY_W-1:0]    ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [KEY_W-1:0]    ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic                div_start;
   logic [HOLD_W-1:0]   div_dividend;
   logic                div_done;
   logic                div_zero;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign key_ok        = {1'b0, req_bus.key_index} < (KEY_IDX_W + 1)'(NUM_KEYS);
   assign req_key       = req_bus.key_index[KEY_W-1:0];
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   assign ram_rd_en   = accept || (state_ff == S_TRD);
   assign ram_rd_addr = (state_ff == S_TRD) ? cnt_ff : req_key;
   assign ram_wr_addr = (state_ff == S_TWR) ? cnt_ff : key_ff;

   // An entry never written since reset reads as a released key with a zero count.
   assign entry = (state_ff == S_TWR) ? (hvalid_ff[cnt_ff] ? ram_rd_data : '0)
                                      : (hvalid_ff[key_ff] ? ram_rd_data : '0);
   assign ent_now    = entry[HOLD_W+1];
   assign ent_before = entry[HOLD_W];
   assign ent_held   = entry[HOLD_W-1:0];
   assign cur        = ent_now | raw_ff;

   // The hold count grows only for a key seen in the frame that has just ended.
   assign tick_held = !ent_now ? '0
                    : (ent_held == HOLD_MAX) ? ent_held : ent_held + 1'b1;

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      key_ok_in    = key_ok_ff;
      raw_in       = raw_ff;
      cnt_in       = cnt_ff;
      hold_in      = hold_ff;
      period_in    = period_ff;
      ans_in       = ans_ff;
      hvalid_in    = hvalid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_ans_in   = rsp_ans_ff;
      ram_wr_en    = 1'b0;
      ram_wr_data  = '0;
      div_start    = 1'b0;
      div_dividend = ent_held - hold_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in   = req_bus.func;
               key_in    = req_key;
               key_ok_in = key_ok;
               raw_in    = req_bus.raw_pressed;
               hold_in   = req_bus.hold_delay;
               period_in = req_bus.repeat_period;
               ans_in    = 1'b0;
               if (req_bus.func == FN_TICK) begin
                  cnt_in   = '0;
                  state_in = S_TRD;
               end else begin
                  state_in = S_QCHK;
               end
            end
         end
         S_QCHK: begin
            ans_in   = 1'b0;
            state_in = S_DONE;
            if (key_ok_ff) begin
               if (raw_ff) begin
                  ram_wr_en         = 1'b1;
                  ram_wr_data       = {1'b1, ent_before, ent_held};
                  hvalid_in[key_ff] = 1'b1;
               end
               unique case (func_ff)
                  FN_PRESSED: ans_in = cur;
                  FN_RELEASE: ans_in = !cur && ent_before;
                  FN_TRIGGER: begin
                     if (cur && !ent_before) begin
                        ans_in = 1'b1;
                     end else if (cur && (hold_ff != '0) && (period_ff != '0)
                                  && (ent_held > hold_ff)) begin
                        div_start = 1'b1;
                        state_in  = S_QDIV;
                     end
                  end
                  default: ans_in = 1'b0;
               endcase
            end
         end
         S_QDIV: begin
            if (div_done) begin
               ans_in   = div_zero;
               state_in = S_DONE;
            end
         end
         S_TRD: begin
            state_in = S_TWR;
         end
         S_TWR: begin
            // The current-frame bit becomes the previous-frame bit and is cleared.
            ram_wr_en         = 1'b1;
            ram_wr_data       = {1'b0, ent_now, tick_held};
            hvalid_in[cnt_ff] = 1'b1;
            if (cnt_ff == KEY_W'(NUM_KEYS - 1)) begin
               ans_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_TRD;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ans_in   = ans_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         hvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hvalid_ff    <= hvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff    <= func_in;
      key_ff     <= key_in;
      key_ok_ff  <= key_ok_in;
      raw_ff     <= raw_in;
      hold_ff    <= hold_in;
      period_ff  <= period_in;
      ans_ff     <= ans_in;
      rsp_ans_ff <= rsp_ans_in;
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.answer = rsp_ans_ff;

   kear_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_KEYS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   kear_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (period_ff),
      .done     (div_done),
      .rem_zero (div_zero)
   );

endmodule

FILE: design/kear_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kear_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: design/kear_rem.sv
// Restoring remainder unit: one quotient bit per cycle, reports a zero remainder.
`timescale 1ns / 1ps

module kear_rem
   import kear_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [HOLD_W-1:0] dividend,
   input  logic [HOLD_W-1:0] divisor,
   output logic              done,
   output logic              rem_zero
);

   localparam int STEP_W = $clog2(HOLD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [HOLD_W-1:0] rem_ff, rem_in;
   logic [HOLD_W-1:0] num_ff, num_in;
   logic [HOLD_W-1:0] den_ff, den_in;
   logic [HOLD_W:0]   shifted;
   logic [HOLD_W:0]   trial;

   always_comb begin
      shifted = {rem_ff, num_ff[HOLD_W-1]};
      trial   = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         num_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         // A set top bit means the trial subtraction went negative.
         rem_in  = trial[HOLD_W] ? shifted[HOLD_W-1:0] : trial[HOLD_W-1:0];
         num_in  = {num_ff[HOLD_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(HOLD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

FILE: tb/sv/key_edge_and_autorepeat_test.sv
// Self-checking testbench for the key edge and auto-repeat tracker.
`timescale 1ns / 1ps

module key_edge_and_autorepeat_test
   import kear_pkg::*;
();

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int KEY_W       = $clog2(NUM_KEYS_DEF);

   logic clock;
   logic reset;

   kear_req_if req_bus ();
   kear_rsp_if rsp_bus ();

   key_edge_and_autorepeat dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predicted state of every key.
   logic [NUM_KEYS_DEF-1:0] key_now;
   logic [NUM_KEYS_DEF-1:0] key_before;
   logic [HOLD_W-1:0]       key_held [NUM_KEYS_DEF];

   logic answer_queue [$];
   int   mismatch_count;
   int   items_sent;
   int   tick_count;
   int   edge_hits;
   int   repeat_hits;
   int   release_hits;
   int   cycle_count;
   int   rsp_stall_left;
   bit   no_gaps;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d answers outstanding", $realtime,
                  answer_queue.size());
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int pause_len();
      return no_gaps ? 0 : $urandom_range(0, 10);
   endfunction

   // Works out the answer for one transaction and advances the key state.
   function automatic logic predict_answer(input func_type f, input logic [7:0] k,
                                           input logic raw, input logic [HOLD_W-1:0] hold,
                                           input logic [HOLD_W-1:0] period);
      logic              cur;
      logic              prev;
      logic              ans;
      logic [HOLD_W-1:0] held;
      logic [KEY_W-1:0]  ki;
      ans = 1'b0;
      ki  = k[KEY_W-1:0];
      if (f == FN_TICK) begin
         key_before = key_now;
         key_now    = '0;
         for (int i = 0; i < NUM_KEYS_DEF; i++) begin
            if (key_before[i]) begin
               if (key_held[i] != HOLD_MAX) key_held[i] = key_held[i] + 1'b1;
            end else begin
               key_held[i] = '0;
            end
         end
      end else if (k < NUM_KEYS_DEF) begin
         cur  = key_now[ki] | raw;
         key_now[ki] = cur;
         prev = key_before[ki];
         held = key_held[ki];
         if (f == FN_PRESSED) begin
            ans = cur;
         end else if (f == FN_TRIGGER) begin
            if (cur && !prev) begin
               ans = 1'b1;
               edge_hits++;
            end else if (cur && hold != 0 && period != 0 && held > hold &&
                         ((held - hold) % period) == 0) begin
               ans = 1'b1;
               repeat_hits++;
            end
         end else begin
            ans = !cur && prev;
            if (ans) release_hits++;
         end
      end
      return ans;
   endfunction

   // Offers one transaction and records its expected answer once accepted.
   // The valid is left high so that a following transaction with no gap runs on.
   task automatic send_item(input func_type f, input logic [7:0] k, input logic raw,
                            input logic [HOLD_W-1:0] hold, input logic [HOLD_W-1:0] period);
      int gap;
      gap = pause_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.func          <= f;
      req_bus.key_index     <= k;
      req_bus.raw_pressed   <= raw;
      req_bus.hold_delay    <= hold;
      req_bus.repeat_period <= period;
      do @(posedge clock); while (!req_bus.ready);
      answer_queue.push_back(predict_answer(f, k, raw, hold, period));
      items_sent++;
      if (f == FN_TICK) tick_count++;
   endtask

   task automatic send_tick();
      send_item(FN_TICK, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Answer checking and random stalling on the response side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready  <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (answer_queue.size() == 0) begin
               $display("%0t: unexpected answer, expected none, got %0b", $realtime,
                        rsp_bus.answer);
               mismatch_count++;
            end else begin
               if (rsp_bus.answer !== answer_queue[0]) begin
                  $display("%0t: answer mismatch, expected %0b, got %0b", $realtime,
                           answer_queue[0], rsp_bus.answer);
                  mismatch_count++;
               end
               void'(answer_queue.pop_front());
            end
            rsp_stall_left = pause_len();
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left--;
         end
         rsp_bus.ready <= (rsp_stall_left == 0);
      end
   end

   // Edges, repeat timing, disabled repeat, out-of-range keys and field extremes.
   task automatic test_directed();
      send_item(FN_PRESSED, 8'd0, 1'b0, 16'd0, 16'd0);
      send_item(FN_RELEASE, 8'd0, 1'b0, 16'd0, 16'd0);
      send_item(FN_TRIGGER, 8'd0, 1'b1, 16'd0, 16'd0);
      send_item(FN_PRESSED, 8'd0, 1'b0, 16'd0, 16'd0);
      send_item(FN_PRESSED, 8'd127, 1'b1, 16'hFFFF, 16'hFFFF);
      send_item(FN_PRESSED, 8'd5, 1'b1, 16'd0, 16'd0);
      send_item(FN_PRESSED, 8'd128, 1'b1, 16'd1, 16'd1);
      send_item(FN_TRIGGER, 8'd255, 1'b1, 16'hFFFF, 16'hFFFF);
      send_item(FN_TICK, 8'd255, 1'b1, 16'hFFFF, 16'hFFFF);
      // A key held over one frame is no longer a rising edge.
      send_item(FN_TRIGGER, 8'd0, 1'b1, 16'd1, 16'd1);
      send_item(FN_RELEASE, 8'd5, 1'b1, 16'd0, 16'd0);
      send_item(FN_RELEASE, 8'd127, 1'b0, 16'd0, 16'd0);
      send_item(FN_RELEASE, 8'd200, 1'b0, 16'd0, 16'd0);
      send_item(FN_TICK, 8'd0, 1'b0, 16'd0, 16'd0);
      send_item(FN_TRIGGER, 8'd0, 1'b1, 16'd1, 16'd1);
      send_item(FN_TRIGGER, 8'd0, 1'b1, 16'd0, 16'd1);
      send_item(FN_TRIGGER, 8'd0, 1'b1, 16'd1, 16'd0);
      send_item(FN_TRIGGER, 8'd0, 1'b1, 16'hFFFF, 16'hFFFF);
      send_item(FN_TICK, 8'd128, 1'b0, 16'd0, 16'd0);
      send_item(FN_TRIGGER, 8'd0, 1'b1, 16'd1, 16'd2);
      send_item(FN_TRIGGER, 8'd0, 1'b0, 16'd1, 16'd1);
      send_item(FN_TRIGGER, 8'd128, 1'b1, 16'd1, 16'd1);
      send_item(FN_TICK, 8'd0, 1'b0, 16'd0, 16'd0);
      send_item(FN_RELEASE, 8'd0, 1'b0, 16'd0, 16'd0);
      send_item(FN_PRESSED, 8'd0, 1'b0, 16'd0, 16'd0);
   endtask

   // Frames of a key scan: each frame polls a few keys that are pressed and released
   // over several frames, with the odd bounce and stray key, then ends with a tick.
   task automatic test_key_scan(input int item_target);
      int                start;
      int                active [3];
      bit                down [3];
      int                left [3];
      int                slot;
      int                extra;
      logic [7:0]        k;
      logic              raw;
      logic [HOLD_W-1:0] hold;
      logic [HOLD_W-1:0] period;
      start = items_sent;
      for (int i = 0; i < 3; i++) begin
         active[i] = $urandom_range(0, NUM_KEYS_DEF - 1);
         down[i]   = 1'b0;
         left[i]   = $urandom_range(1, 4);
      end
      while (items_sent - start < item_target) begin
         extra = $urandom_range(0, 3);
         for (int q = 0; q < 3 + extra; q++) begin
            slot = (q < 3) ? q : $urandom_range(0, 2);
            k    = (($urandom_range(0, 9)) == 0) ? 8'($urandom) : 8'(active[slot]);
            raw  = down[slot];
            if ($urandom_range(0, 11) == 0) raw = ~raw;
            if ($urandom_range(0, 7) == 0) begin
               hold   = 16'($urandom);
               period = 16'($urandom);
            end else begin
               hold   = 16'($urandom_range(0, 4));
               period = 16'($urandom_range(0, 3));
            end
            send_item(func_type'($urandom_range(1, 3)), k, raw, hold, period);
         end
         send_tick();
         for (int i = 0; i < 3; i++) begin
            left[i]--;
            if (left[i] == 0) begin
               down[i] = ~down[i];
               left[i] = down[i] ? $urandom_range(1, 12) : $urandom_range(1, 4);
               if (!down[i] && $urandom_range(0, 2) == 0)
                  active[i] = $urandom_range(0, NUM_KEYS_DEF - 1);
            end
         end
      end
   endtask

   task automatic test_back_to_back(input int item_target);
      no_gaps = 1'b1;
      test_key_scan(item_target);
      no_gaps = 1'b0;
   endtask

   task automatic test_random_fields(input int item_target);
      for (int i = 0; i < item_target; i++) begin
         send_item(func_type'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                   16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.func          = FN_TICK;
      req_bus.key_index     = '0;
      req_bus.raw_pressed   = 1'b0;
      req_bus.hold_delay    = '0;
      req_bus.repeat_period = '0;
      key_now               = '0;
      key_before            = '0;
      for (int i = 0; i < NUM_KEYS_DEF; i++) key_held[i] = '0;
      mismatch_count = 0;
      items_sent     = 0;
      tick_count     = 0;
      edge_hits      = 0;
      repeat_hits    = 0;
      release_hits   = 0;
      no_gaps        = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_key_scan(700);
      test_back_to_back(150);
      test_random_fields(175);
      req_bus.valid <= 1'b0;

      while (answer_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Ran %0d transactions: %0d frame ticks and %0d key queries.", items_sent,
               tick_count, items_sent - tick_count);
      $display("Answers included %0d rising-edge triggers, %0d auto-repeat triggers",
               edge_hits, repeat_hits);
      $display("and %0d releases.", release_hits);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
